>>> src/ocm_pkg.sv
// ----------------------------------------------------------------------------
// ocm_pkg
// Codes and constants shared by the optimiser convergence monitor.
// ----------------------------------------------------------------------------
package ocm_pkg;

   // item actions
   localparam logic [1:0] ACT_GRAD  = 2'd0;
   localparam logic [1:0] ACT_SCORE = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // configuration register indexes
   localparam logic [2:0] REG_MEMORY    = 3'd0;
   localparam logic [2:0] REG_CONV_GRAD = 3'd1;
   localparam logic [2:0] REG_CONV_SCR  = 3'd2;
   localparam logic [2:0] REG_MAX_STEPS = 3'd3;
   localparam logic [2:0] REG_MIN_STEPS = 3'd4;
   localparam logic [2:0] REG_STEP_SIZE = 3'd5;

   // reset values
   localparam logic [15:0] RST_MEMORY    = 16'd58982;
   localparam logic [31:0] RST_CONV_GRAD = 32'd66;
   localparam logic [31:0] RST_CONV_SCR  = 32'd66;
   localparam logic [23:0] RST_MAX_STEPS = 24'd10000;
   localparam logic [23:0] RST_MIN_STEPS = 24'd10;
   localparam logic [31:0] RST_STEP_SIZE = 32'd6554;
   localparam logic [31:0] RST_CEILING   = 32'd65540;
   localparam logic [31:0] RST_FLOOR     = 32'd655;

   // step size adaptation
   localparam logic [31:0] K_TEN      = 32'd10;
   // reciprocals, exact for any 32-bit operand:
   // x/10 = (x*K_RECIP_10) >> 35, x/5 = (x*K_RECIP_5) >> 34, x/50 = (x*K_RECIP_50) >> 36
   localparam logic [31:0] K_RECIP_10 = 32'hCCCC_CCCD;
   localparam logic [31:0] K_RECIP_5  = 32'hCCCC_CCCD;
   localparam logic [31:0] K_RECIP_50 = 32'h51EB_851F;
   localparam logic signed [4:0] TREND_RISE = 5'sd2;
   localparam logic signed [4:0] TREND_FALL = 5'sd1;
   localparam logic signed [4:0] TREND_HIGH = 5'sd10;
   localparam logic signed [4:0] TREND_LOW  = -5'sd5;

   localparam logic [16:0] MEM_ONE = 17'h10000;

endpackage

>>> src/optimiser_convergence_monitor_top.sv
// ----------------------------------------------------------------------------
// optimiser_convergence_monitor_top
// Convergence monitor for an iterative optimiser: moving averages, sticky
// stop flags and step size adaptation, on one multiplier and one divider.
// ----------------------------------------------------------------------------
// One item is taken at a time and req_stall stays high until its result has
// been taken, then the block returns to idle before the next item. A gradient
// check holds the block until rsp_valid rises while the power m^(step+1) is
// formed by squaring (states AV_PW_R, AV_PW_B and AV_PW_E per bit of step+1)
// and the bit-serial divider forms the average; convergence that resets the
// step size adds the state GR_END. A score check with a non-zero step adds
// up to two short divisions (delta and correction) and a second average with
// its long division; with step zero it adds only the trend update and any
// step size change. A clear holds the block in the bound states, an unused
// action goes straight to the result. A write of initial_step_size keeps the
// configuration port busy while the bounds are derived.
// ----------------------------------------------------------------------------
module optimiser_convergence_monitor_top #(
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [23:0] req_step,
   input  logic [31:0] req_grad_norm,
   input  logic signed [31:0] req_score,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_converged,
   output logic        rsp_reached_max,
   output logic        rsp_gradient_done,
   output logic        rsp_score_done,
   output logic [23:0] rsp_stop_step,
   output logic [31:0] rsp_current_step_size,
   output logic [31:0] rsp_gradient_average,
   output logic [31:0] rsp_score_average,
   output logic [31:0] rsp_gradient_at_trigger,
   output logic [31:0] rsp_delta_at_trigger,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam logic [5:0] ST_IDLE     = 6'd0;
   localparam logic [5:0] ST_OUT      = 6'd1;
   localparam logic [5:0] ST_DIV      = 6'd2;
   localparam logic [5:0] ST_BND_MUL  = 6'd3;
   localparam logic [5:0] ST_BND_DIV  = 6'd4;
   localparam logic [5:0] ST_BND_END  = 6'd5;
   localparam logic [5:0] ST_SC_START = 6'd6;
   localparam logic [5:0] ST_SC_DELTA = 6'd7;
   localparam logic [5:0] ST_SC_CORR  = 6'd8;
   localparam logic [5:0] ST_SC_CDIV  = 6'd9;
   localparam logic [5:0] ST_SC_CEND  = 6'd10;
   localparam logic [5:0] ST_AV_PW_R  = 6'd11;
   localparam logic [5:0] ST_AV_PW_B  = 6'd12;
   localparam logic [5:0] ST_AV_PW_E  = 6'd13;
   localparam logic [5:0] ST_AV_M1    = 6'd14;
   localparam logic [5:0] ST_AV_M2    = 6'd15;
   localparam logic [5:0] ST_AV_M3    = 6'd16;
   localparam logic [5:0] ST_SC_MULH  = 6'd17;
   localparam logic [5:0] ST_SC_MULL  = 6'd18;
   localparam logic [5:0] ST_SC_SUM   = 6'd19;
   localparam logic [5:0] ST_SC_SAVG  = 6'd20;
   localparam logic [5:0] ST_SC_TREND = 6'd21;
   localparam logic [5:0] ST_SC_DNEND = 6'd22;
   localparam logic [5:0] ST_SC_UPDIV = 6'd23;
   localparam logic [5:0] ST_GR_START = 6'd25;
   localparam logic [5:0] ST_GR_AVG   = 6'd26;
   localparam logic [5:0] ST_GR_END   = 6'd27;

   localparam logic [5:0] DIV_SHORT = 6'd32;
   localparam logic [5:0] DIV_LONG  = 6'd49;

   logic [5:0]  state_ff, state_in;
   // configuration
   logic [15:0] mem_ff, mem_in;
   logic [31:0] cgrad_ff, cgrad_in, cscore_ff, cscore_in;
   logic [23:0] maxs_ff, maxs_in, mins_ff, mins_in;
   // architectural state
   logic [31:0] prev_ff, prev_in, gavg_ff, gavg_in, savg_ff, savg_in;
   logic [31:0] s_ff, s_in, ceil_ff, ceil_in, floor_ff, floor_in;
   logic signed [4:0] cnt_ff, cnt_in;
   logic [23:0] stop_ff, stop_in;
   logic        fmax_ff, fmax_in, fgrad_ff, fgrad_in, fscore_ff, fscore_in;
   logic        conv_ff, conv_in;
   logic [31:0] tgrad_ff, tgrad_in, tdelta_ff, tdelta_in;
   // item
   logic [23:0] step_ff, step_in;
   logic [31:0] grad_ff, grad_in, score_ff, score_in;
   logic        item_ff, item_in;
   // working registers
   logic [24:0] exp_ff, exp_in;
   logic [16:0] pr_ff, pr_in, den_ff, den_in;
   logic [15:0] pb_ff, pb_in;
   logic [48:0] acc_ff, acc_in, t_ff, t_in;
   logic        avsel_ff, avsel_in;
   logic [5:0]  avret_ff, avret_in;
   logic [31:0] delta_ff, delta_in, corr_ff, corr_in;
   logic [81:0] wide_ff, wide_in;
   logic [31:0] rem_ff, rem_in, dden_ff, dden_in;
   logic [48:0] divn_ff, divn_in;
   logic [5:0]  dcnt_ff, dcnt_in, dret_ff, dret_in;
   logic [63:0] mulp_ff;
   // shared multiplier and divider start
   logic [31:0] mul_a, mul_b;
   logic        div_go, div_long;
   logic [63:0] div_num;
   logic [31:0] div_den;
   logic [5:0]  div_ret;
   // helpers
   logic [32:0] trial, diff, adiff;
   logic [31:0] aprev, avg_sel, x_sel, sat_t, savg_new, gavg_new, s_dn;
   logic [31:0] q5, five_q, s_dn_raw, s_up;
   logic [32:0] s_up_sum;
   logic [81:0] wide_sh;
   logic        ge, gflag_new;

   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   assign rsp_converged           = conv_ff;
   assign rsp_reached_max         = fmax_ff;
   assign rsp_gradient_done       = fgrad_ff;
   assign rsp_score_done          = fscore_ff;
   assign rsp_stop_step           = stop_ff;
   assign rsp_current_step_size   = s_ff;
   assign rsp_gradient_average    = gavg_ff;
   assign rsp_score_average       = savg_ff;
   assign rsp_gradient_at_trigger = tgrad_ff;
   assign rsp_delta_at_trigger    = tdelta_ff;

   always_comb begin
      trial    = {rem_ff, divn_ff[48]};
      ge       = trial >= {1'b0, dden_ff};
      diff     = {score_ff[31], score_ff} - {prev_ff[31], prev_ff};
      adiff    = diff[32] ? (33'd0 - diff) : diff;
      aprev    = prev_ff[31] ? (32'd0 - prev_ff) : prev_ff;
      avg_sel  = avsel_ff ? savg_ff : gavg_ff;
      x_sel    = avsel_ff ? delta_ff : grad_ff;
      sat_t    = (|divn_ff[48:32]) ? 32'hFFFF_FFFF : divn_ff[31:0];
      wide_sh  = wide_ff >> FRACTION_BITS;
      savg_new = (|wide_sh[81:32]) ? 32'hFFFF_FFFF : wide_sh[31:0];
      gavg_new = sat_t;
      gflag_new = fgrad_ff || (gavg_new < cgrad_ff);
      // s*4/5 = s - ceil(s/5)
      q5       = {2'd0, mulp_ff[63:34]};
      five_q   = (q5 << 2) + q5;
      s_dn_raw = s_ff - q5 - {31'd0, (s_ff != five_q)};
      s_dn     = (s_dn_raw > floor_ff) ? s_dn_raw : floor_ff;
      // s*51/50 = s + s/50
      s_up_sum = {1'b0, s_ff} + {5'd0, mulp_ff[63:36]};
      s_up     = s_up_sum[32] ? 32'hFFFF_FFFF : s_up_sum[31:0];
   end

   always_comb begin
      state_in = state_ff;
      mem_in = mem_ff; cgrad_in = cgrad_ff; cscore_in = cscore_ff;
      maxs_in = maxs_ff; mins_in = mins_ff;
      prev_in = prev_ff; gavg_in = gavg_ff; savg_in = savg_ff;
      s_in = s_ff; ceil_in = ceil_ff; floor_in = floor_ff; cnt_in = cnt_ff;
      stop_in = stop_ff; fmax_in = fmax_ff; fgrad_in = fgrad_ff;
      fscore_in = fscore_ff; conv_in = conv_ff;
      tgrad_in = tgrad_ff; tdelta_in = tdelta_ff;
      step_in = step_ff; grad_in = grad_ff; score_in = score_ff; item_in = item_ff;
      exp_in = exp_ff; pr_in = pr_ff; pb_in = pb_ff; den_in = den_ff;
      acc_in = acc_ff; t_in = t_ff; avsel_in = avsel_ff; avret_in = avret_ff;
      delta_in = delta_ff; corr_in = corr_ff; wide_in = wide_ff;
      rem_in = rem_ff; dden_in = dden_ff; divn_in = divn_ff;
      dcnt_in = dcnt_ff; dret_in = dret_ff;
      mul_a = 32'd0; mul_b = 32'd0;
      div_go = 1'b0; div_long = 1'b0; div_num = 64'd0; div_den = 32'd1;
      div_ret = ST_IDLE;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               unique case (csr_index)
                  ocm_pkg::REG_MEMORY:    mem_in = csr_data[15:0];
                  ocm_pkg::REG_CONV_GRAD: cgrad_in = csr_data;
                  ocm_pkg::REG_CONV_SCR:  cscore_in = csr_data;
                  ocm_pkg::REG_MAX_STEPS: maxs_in = csr_data[23:0];
                  ocm_pkg::REG_MIN_STEPS: mins_in = csr_data[23:0];
                  ocm_pkg::REG_STEP_SIZE: begin
                     s_in = csr_data;
                     item_in = 1'b0;
                     state_in = ST_BND_MUL;
                  end
                  default: ;
               endcase
            end else if (req_valid) begin
               step_in = req_step;
               grad_in = req_grad_norm;
               score_in = req_score;
               item_in = 1'b1;
               unique case (req_action)
                  ocm_pkg::ACT_GRAD:  state_in = ST_GR_START;
                  ocm_pkg::ACT_SCORE: state_in = ST_SC_START;
                  ocm_pkg::ACT_CLEAR: begin
                     prev_in = 32'd0; gavg_in = 32'd0; savg_in = 32'd0;
                     stop_in = 24'd0; cnt_in = 5'sd0;
                     state_in = ST_BND_MUL;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         ST_DIV: begin
            rem_in = ge ? 32'(trial - {1'b0, dden_ff}) : trial[31:0];
            divn_in = {divn_ff[47:0], ge};
            dcnt_in = dcnt_ff - 6'd1;
            if (dcnt_ff == 6'd1) state_in = dret_ff;
         end
         ST_BND_MUL: begin
            mul_a = s_ff; mul_b = ocm_pkg::K_TEN;
            state_in = ST_BND_DIV;
         end
         ST_BND_DIV: begin
            ceil_in = (|mulp_ff[63:32]) ? 32'hFFFF_FFFF : mulp_ff[31:0];
            mul_a = s_ff; mul_b = ocm_pkg::K_RECIP_10;
            state_in = ST_BND_END;
         end
         ST_BND_END: begin
            floor_in = {3'd0, mulp_ff[63:35]};
            state_in = item_ff ? ST_OUT : ST_IDLE;
         end
         ST_SC_START: begin
            if (step_ff == 24'd0) begin
               state_in = ST_SC_TREND;
            end else if (prev_ff == 32'd0) begin
               delta_in = 32'hFFFF_FFFF;
               state_in = ST_SC_CORR;
            end else begin
               div_go = 1'b1; div_num = {31'd0, adiff} << FRACTION_BITS;
               div_den = aprev; div_ret = ST_SC_DELTA;
            end
         end
         ST_SC_DELTA: begin
            delta_in = divn_ff[31:0];
            state_in = ST_SC_CORR;
         end
         ST_SC_CORR: begin
            if (ceil_ff == 32'd0) begin
               corr_in = 32'd1 << FRACTION_BITS;
               state_in = ST_SC_CEND;
            end else begin
               mul_a = s_ff; mul_b = ocm_pkg::K_TEN;
               state_in = ST_SC_CDIV;
            end
         end
         ST_SC_CDIV: begin
            div_go = 1'b1; div_num = {28'd0, mulp_ff[35:0]} << FRACTION_BITS;
            div_den = ceil_ff; div_ret = ST_SC_CEND;
            corr_in = 32'd0;
         end
         ST_SC_CEND: begin
            if (ceil_ff != 32'd0) corr_in = divn_ff[31:0];
            exp_in = {1'b0, step_ff} + 25'd1;
            pr_in = ocm_pkg::MEM_ONE; pb_in = mem_ff;
            avsel_in = 1'b1; avret_in = ST_SC_MULH;
            state_in = ST_AV_PW_R;
         end
         ST_AV_PW_R: begin
            if (exp_ff == 25'd0) begin
               state_in = ST_AV_M1;
            end else begin
               mul_a = {15'd0, pr_ff}; mul_b = {16'd0, pb_ff};
               state_in = ST_AV_PW_B;
            end
         end
         ST_AV_PW_B: begin
            if (exp_ff[0]) pr_in = mulp_ff[32:16];
            mul_a = {16'd0, pb_ff}; mul_b = {16'd0, pb_ff};
            state_in = ST_AV_PW_E;
         end
         ST_AV_PW_E: begin
            pb_in = mulp_ff[31:16];
            exp_in = exp_ff >> 1;
            state_in = ST_AV_PW_R;
         end
         ST_AV_M1: begin
            den_in = ocm_pkg::MEM_ONE - pr_ff;
            mul_a = {16'd0, mem_ff}; mul_b = avg_sel;
            state_in = ST_AV_M2;
         end
         ST_AV_M2: begin
            acc_in = mulp_ff[48:0];
            mul_a = {15'd0, ocm_pkg::MEM_ONE - {1'b0, mem_ff}}; mul_b = x_sel;
            state_in = ST_AV_M3;
         end
         ST_AV_M3: begin
            div_go = 1'b1; div_long = 1'b1;
            div_num = {15'd0, acc_ff + mulp_ff[48:0]};
            div_den = {15'd0, den_ff}; div_ret = avret_ff;
         end
         ST_SC_MULH: begin
            t_in = divn_ff;
            mul_a = {15'd0, divn_ff[48:32]}; mul_b = corr_ff;
            state_in = ST_SC_MULL;
         end
         ST_SC_MULL: begin
            wide_in = {mulp_ff[49:0], 32'd0};
            mul_a = t_ff[31:0]; mul_b = corr_ff;
            state_in = ST_SC_SUM;
         end
         ST_SC_SUM: begin
            wide_in = wide_ff + {18'd0, mulp_ff};
            state_in = ST_SC_SAVG;
         end
         ST_SC_SAVG: begin
            savg_in = savg_new;
            if (savg_new < cscore_ff) begin
               tdelta_in = delta_ff;
               fscore_in = 1'b1;
            end
            state_in = ST_SC_TREND;
         end
         ST_SC_TREND: begin
            prev_in = score_ff;
            state_in = ST_GR_START;
            if ($signed(score_ff) > $signed(prev_ff)) begin
               cnt_in = cnt_ff + ocm_pkg::TREND_RISE;
               if (cnt_ff + ocm_pkg::TREND_RISE >= ocm_pkg::TREND_HIGH) begin
                  cnt_in = 5'sd0;
                  mul_a = s_ff; mul_b = ocm_pkg::K_RECIP_5;
                  state_in = ST_SC_DNEND;
               end
            end else begin
               cnt_in = cnt_ff - ocm_pkg::TREND_FALL;
               if (cnt_ff - ocm_pkg::TREND_FALL <= ocm_pkg::TREND_LOW) begin
                  cnt_in = 5'sd0;
                  mul_a = s_ff; mul_b = ocm_pkg::K_RECIP_50;
                  state_in = ST_SC_UPDIV;
               end
            end
         end
         ST_SC_DNEND: begin
            s_in = s_dn;
            state_in = ST_GR_START;
         end
         ST_SC_UPDIV: begin
            s_in = (s_up < ceil_ff) ? s_up : ceil_ff;
            state_in = ST_GR_START;
         end
         ST_GR_START: begin
            if (step_ff >= maxs_ff) fmax_in = 1'b1;
            exp_in = {1'b0, step_ff} + 25'd1;
            pr_in = ocm_pkg::MEM_ONE; pb_in = mem_ff;
            avsel_in = 1'b0; avret_in = ST_GR_AVG;
            state_in = ST_AV_PW_R;
         end
         ST_GR_AVG: begin
            gavg_in = gavg_new;
            fgrad_in = gflag_new;
            if (gavg_new < cgrad_ff) tgrad_in = grad_ff;
            conv_in = (fmax_ff || gflag_new || fscore_ff) && (step_ff > mins_ff);
            state_in = ST_OUT;
            if (conv_in) begin
               stop_in = step_ff;
               mul_a = ceil_ff; mul_b = ocm_pkg::K_RECIP_10;
               state_in = ST_GR_END;
            end
         end
         ST_GR_END: begin
            s_in = {3'd0, mulp_ff[63:35]};
            state_in = ST_OUT;
         end
         default: state_in = ST_IDLE;
      endcase

      if (div_go) begin
         dden_in = div_den;
         dret_in = div_ret;
         if (div_long) begin
            rem_in = 32'd0;
            divn_in = div_num[48:0];
            dcnt_in = DIV_LONG;
            state_in = ST_DIV;
         end else if (div_num[63:32] >= div_den) begin
            divn_in = {17'd0, 32'hFFFF_FFFF};
            state_in = div_ret;
         end else begin
            rem_in = div_num[63:32];
            divn_in = {div_num[31:0], 17'd0};
            dcnt_in = DIV_SHORT;
            state_in = ST_DIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mem_ff <= ocm_pkg::RST_MEMORY;
         cgrad_ff <= ocm_pkg::RST_CONV_GRAD;
         cscore_ff <= ocm_pkg::RST_CONV_SCR;
         maxs_ff <= ocm_pkg::RST_MAX_STEPS;
         mins_ff <= ocm_pkg::RST_MIN_STEPS;
         prev_ff <= 32'd0; gavg_ff <= 32'd0; savg_ff <= 32'd0;
         s_ff <= ocm_pkg::RST_STEP_SIZE;
         ceil_ff <= ocm_pkg::RST_CEILING;
         floor_ff <= ocm_pkg::RST_FLOOR;
         cnt_ff <= 5'sd0; stop_ff <= 24'd0;
         fmax_ff <= 1'b0; fgrad_ff <= 1'b0; fscore_ff <= 1'b0; conv_ff <= 1'b0;
         tgrad_ff <= 32'd0; tdelta_ff <= 32'd0;
         item_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mem_ff <= mem_in; cgrad_ff <= cgrad_in; cscore_ff <= cscore_in;
         maxs_ff <= maxs_in; mins_ff <= mins_in;
         prev_ff <= prev_in; gavg_ff <= gavg_in; savg_ff <= savg_in;
         s_ff <= s_in; ceil_ff <= ceil_in; floor_ff <= floor_in;
         cnt_ff <= cnt_in; stop_ff <= stop_in;
         fmax_ff <= fmax_in; fgrad_ff <= fgrad_in; fscore_ff <= fscore_in;
         conv_ff <= conv_in;
         tgrad_ff <= tgrad_in; tdelta_ff <= tdelta_in;
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in; grad_ff <= grad_in; score_ff <= score_in;
      exp_ff <= exp_in; pr_ff <= pr_in; pb_ff <= pb_in; den_ff <= den_in;
      acc_ff <= acc_in; t_ff <= t_in; avsel_ff <= avsel_in; avret_ff <= avret_in;
      delta_ff <= delta_in; corr_ff <= corr_in; wide_ff <= wide_in;
      rem_ff <= rem_in; dden_ff <= dden_in; divn_ff <= divn_in;
      dcnt_ff <= dcnt_in; dret_ff <= dret_in;
      mulp_ff <= mul_a * mul_b;
   end

   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result pending while items are taken");

   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !csr_ready)
      else $error("configuration port open during an item");

   a_trend_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cnt_ff >= -5'sd4 && cnt_ff <= 5'sd9))
      else $error("trend counter out of range at rest");

   a_grad_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(fgrad_ff))
      else $error("gradient flag cleared");

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the optimiser convergence monitor: optimiser-like
// runs and random noise are fed through the item channel under random
// gaps and stalls, and every result is compared with an in-bench prediction
// of averages, stop flags and step size adaptation across several register
// settings.
// ----------------------------------------------------------------------------
module tb;

   localparam int N_PHASES   = 8;
   localparam int PHASE_LEN  = 190;
   localparam int IDLE_LIMIT = 12000;
   localparam int HOLD_LEN   = 2500;
   localparam int FRACTION_BITS_TB = 16;
   localparam logic [1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [23:0]        step;
      logic [31:0]        grad;
      logic signed [31:0] score;
   } iter_type;

   typedef struct packed {
      logic        converged;
      logic        reached_max;
      logic        gradient_done;
      logic        score_done;
      logic [23:0] stop_step;
      logic [31:0] step_size;
      logic [31:0] grad_avg;
      logic [31:0] score_avg;
      logic [31:0] grad_trig;
      logic [31:0] delta_trig;
   } status_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_action = 0;
   logic [23:0] req_step = 0;
   logic [31:0] req_grad_norm = 0;
   logic signed [31:0] req_score = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_converged, rsp_reached_max, rsp_gradient_done, rsp_score_done;
   logic [23:0] rsp_stop_step;
   logic [31:0] rsp_current_step_size, rsp_gradient_average, rsp_score_average;
   logic [31:0] rsp_gradient_at_trigger, rsp_delta_at_trigger;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   optimiser_convergence_monitor_top dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // monitor state copy
   logic [15:0] m_memory;
   logic [31:0] m_thr_grad, m_thr_score, m_init_size;
   logic [23:0] m_max_steps, m_min_steps;
   logic [31:0] m_prev_score, m_grad_avg, m_score_avg;
   logic [31:0] m_size, m_ceiling, m_floor;
   int          m_trend;
   logic [23:0] m_stop_step;
   logic        m_max, m_grad, m_score, m_conv;
   logic [31:0] m_grad_trig, m_delta_trig;

   iter_type   pending_items[$];
   status_type expected_status[$];
   int errors = 0;
   int results_seen = 0;
   int converged_seen = 0;
   int idle_cycles = 0;

   function automatic logic [31:0] sat32(logic [127:0] v);
      return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic void load_bounds(logic [31:0] s);
      m_ceiling = sat32(128'(s) * 10);
      m_floor   = s / 10;
   endfunction

   function automatic logic [63:0] decay_power(logic [63:0] e);
      logic [63:0] r, b;
      r = 64'd65536;
      b = 64'(m_memory);
      while (e != 0) begin
         if (e[0]) r = (r * b) >> 16;
         b = (b * b) >> 16;
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic logic [63:0] unbiased_avg(logic [63:0] avg, logic [63:0] x,
                                                logic [63:0] stepv);
      logic [63:0] m, d;
      m = 64'(m_memory);
      d = 64'd65536 - decay_power(stepv + 1);
      return (m * avg + (64'd65536 - m) * x) / d;
   endfunction

   function automatic void gradient_update(logic [23:0] stepv, logic [31:0] g);
      if (stepv >= m_max_steps) m_max = 1;
      m_grad_avg = sat32(128'(unbiased_avg(64'(m_grad_avg), 64'(g), 64'(stepv))));
      if (m_grad_avg < m_thr_grad) begin
         m_grad_trig = g;
         m_grad = 1;
      end
      m_conv = (m_max || m_grad || m_score) && stepv > m_min_steps;
      if (m_conv) begin
         m_stop_step = stepv;
         m_size = m_ceiling / 10;
      end
   endfunction

   function automatic void score_update(logic [23:0] stepv, logic signed [31:0] sc);
      longint prev, diff;
      logic [63:0] ad, ap, corr, t;
      logic [31:0] delta, s;
      prev = longint'($signed(m_prev_score));
      if (stepv > 0) begin
         if (prev == 0) begin
            delta = 32'hFFFF_FFFF;
         end else begin
            diff = longint'(sc) - prev;
            ad = (diff < 0) ? -diff : diff;
            ap = (prev < 0) ? -prev : prev;
            delta = sat32(128'((ad << FRACTION_BITS_TB) / ap));
         end
         if (m_ceiling == 0) corr = 64'd1 << FRACTION_BITS_TB;
         else corr = 64'(sat32(128'(((64'(m_size) * 10) << FRACTION_BITS_TB)
                                    / 64'(m_ceiling))));
         t = unbiased_avg(64'(m_score_avg), 64'(delta), 64'(stepv));
         m_score_avg = sat32((128'(t) * 128'(corr)) >> FRACTION_BITS_TB);
         if (m_score_avg < m_thr_score) begin
            m_delta_trig = delta;
            m_score = 1;
         end
      end
      if (longint'(sc) > prev) begin
         m_trend += 2;
         if (m_trend >= 10) begin
            s = 32'((64'(m_size) * 4) / 5);
            m_trend = 0;
            m_size = (s > m_floor) ? s : m_floor;
         end
      end else begin
         m_trend -= 1;
         if (m_trend <= -5) begin
            s = sat32((128'(m_size) * 51) / 50);
            m_trend = 0;
            m_size = (s < m_ceiling) ? s : m_ceiling;
         end
      end
      m_prev_score = sc;
   endfunction

   function automatic status_type monitor_status(iter_type it);
      status_type r;
      case (it.action)
         ocm_pkg::ACT_CLEAR: begin
            m_prev_score = 0;
            m_grad_avg = 0;
            m_score_avg = 0;
            load_bounds(m_size);
            m_stop_step = 0;
            m_trend = 0;
         end
         ocm_pkg::ACT_SCORE: begin
            score_update(it.step, it.score);
            gradient_update(it.step, it.grad);
         end
         ocm_pkg::ACT_GRAD: gradient_update(it.step, it.grad);
         default: ;
      endcase
      r.converged = m_conv;
      r.reached_max = m_max;
      r.gradient_done = m_grad;
      r.score_done = m_score;
      r.stop_step = m_stop_step;
      r.step_size = m_size;
      r.grad_avg = m_grad_avg;
      r.score_avg = m_score_avg;
      r.grad_trig = m_grad_trig;
      r.delta_trig = m_delta_trig;
      return r;
   endfunction

   function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
         ocm_pkg::REG_MEMORY:    m_memory = v[15:0];
         ocm_pkg::REG_CONV_GRAD: m_thr_grad = v;
         ocm_pkg::REG_CONV_SCR:  m_thr_score = v;
         ocm_pkg::REG_MAX_STEPS: m_max_steps = v[23:0];
         ocm_pkg::REG_MIN_STEPS: m_min_steps = v[23:0];
         ocm_pkg::REG_STEP_SIZE: begin
            m_init_size = v;
            m_size = v;
            load_bounds(v);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // item driver: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_status.push_back(monitor_status({req_action, req_step,
                                                      req_grad_norm, req_score}));
            idle_cycles = 0;
         end
         if (req_valid && req_stall) begin
            req_valid <= 1;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else if (pending_items.size() > 0) begin
            iter_type it;
            it = pending_items.pop_front();
            req_valid <= 1;
            req_action <= it.action;
            req_step <= it.step;
            req_grad_norm <= it.grad;
            req_score <= it.score;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 25);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end
            burst_left--;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   int hold_left = 0;
   bit hold_done = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      if (!hold_done && results_seen >= 400) begin
         hold_done = 1;
         hold_left = HOLD_LEN;
      end
      if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         idle_cycles = 0;
         results_seen <= results_seen + 1;
         if (expected_status.size() == 0) begin
            $display("unexpected result item");
            errors++;
         end else begin
            status_type e;
            e = expected_status.pop_front();
            if (rsp_converged) converged_seen++;
            if (rsp_converged != e.converged)
               report_mismatch("converged", 32'(rsp_converged), 32'(e.converged));
            if (rsp_reached_max != e.reached_max)
               report_mismatch("reached_max", 32'(rsp_reached_max), 32'(e.reached_max));
            if (rsp_gradient_done != e.gradient_done)
               report_mismatch("gradient_done", 32'(rsp_gradient_done),
                               32'(e.gradient_done));
            if (rsp_score_done != e.score_done)
               report_mismatch("score_done", 32'(rsp_score_done), 32'(e.score_done));
            if (rsp_stop_step != e.stop_step)
               report_mismatch("stop_step", 32'(rsp_stop_step), 32'(e.stop_step));
            if (rsp_current_step_size != e.step_size)
               report_mismatch("step_size", rsp_current_step_size, e.step_size);
            if (rsp_gradient_average != e.grad_avg)
               report_mismatch("gradient_average", rsp_gradient_average, e.grad_avg);
            if (rsp_score_average != e.score_avg)
               report_mismatch("score_average", rsp_score_average, e.score_avg);
            if (rsp_gradient_at_trigger != e.grad_trig)
               report_mismatch("gradient_at_trigger", rsp_gradient_at_trigger,
                               e.grad_trig);
            if (rsp_delta_at_trigger != e.delta_trig)
               report_mismatch("delta_at_trigger", rsp_delta_at_trigger, e.delta_trig);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) idle_cycles = 0;
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout, %0d results outstanding", expected_status.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, v);
      csr_valid <= 0;
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_status.size() > 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   function automatic iter_type mk(logic [1:0] a, logic [23:0] s, logic [31:0] g,
                                   logic [31:0] sc);
      iter_type it;
      it.action = a;
      it.step = s;
      it.grad = g;
      it.score = sc;
      return it;
   endfunction

   function automatic iter_type noise_item();
      return mk(2'($urandom_range(0, 3)),
                ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                            : 24'($urandom_range(0, 300)),
                $urandom, $urandom);
   endfunction

   // optimiser-like run: clear, then consecutive steps
   task automatic queue_run(int n);
      logic [23:0] s;
      longint sc;
      logic [63:0] g;
      int a;
      s = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'd0;
      sc = longint'($urandom_range(1 << 12, 1 << 26));
      if ($urandom_range(0, 1)) sc = -sc;
      g = 64'($urandom_range(1 << 10, 1 << 24));
      pending_items.push_back(mk(ocm_pkg::ACT_CLEAR, s, $urandom, $urandom));
      for (int i = 0; i < n; i++) begin
         a = $urandom_range(0, 9);
         if (a == 0) pending_items.push_back(noise_item());
         pending_items.push_back(mk((a < 3) ? ocm_pkg::ACT_GRAD : ocm_pkg::ACT_SCORE,
                                    s, g[31:0], sc[31:0]));
         s++;
         g = (g * 7) / 8 + 64'($urandom_range(0, 64));
         sc = sc + longint'($urandom_range(0, 1 << 12)) - (1 << 11)
              + (($urandom_range(0, 2) == 0) ? 0 : longint'($urandom_range(0, 1 << 8)));
      end
   endtask

   task automatic set_phase(int p);
      case (p)
         1: begin
            write_reg(ocm_pkg::REG_MEMORY, 0);
            write_reg(ocm_pkg::REG_CONV_GRAD, 0);
            write_reg(ocm_pkg::REG_CONV_SCR, 0);
            write_reg(ocm_pkg::REG_MAX_STEPS, 0);
            write_reg(ocm_pkg::REG_MIN_STEPS, 0);
            write_reg(ocm_pkg::REG_STEP_SIZE, 0);
         end
         2: begin
            write_reg(ocm_pkg::REG_MEMORY, 32'hFFFF);
            write_reg(ocm_pkg::REG_CONV_GRAD, 32'hFFFF_FFFF);
            write_reg(ocm_pkg::REG_CONV_SCR, 32'hFFFF_FFFF);
            write_reg(ocm_pkg::REG_MAX_STEPS, 32'hFF_FFFF);
            write_reg(ocm_pkg::REG_MIN_STEPS, 32'hFF_FFFF);
            write_reg(ocm_pkg::REG_STEP_SIZE, 32'hFFFF_FFFF);
         end
         default: begin
            write_reg(ocm_pkg::REG_MEMORY, $urandom_range(30000, 65535));
            write_reg(ocm_pkg::REG_CONV_GRAD, $urandom_range(0, 1 << 21));
            write_reg(ocm_pkg::REG_CONV_SCR, $urandom_range(0, 1 << 18));
            write_reg(ocm_pkg::REG_MAX_STEPS, $urandom_range(5, 3000));
            write_reg(ocm_pkg::REG_MIN_STEPS, $urandom_range(0, 40));
            write_reg(ocm_pkg::REG_STEP_SIZE, ($urandom_range(0, 3) == 0) ? $urandom
                                               : $urandom_range(0, 1 << 20));
         end
      endcase
   endtask

   initial begin
      m_memory = ocm_pkg::RST_MEMORY;
      m_thr_grad = ocm_pkg::RST_CONV_GRAD;
      m_thr_score = ocm_pkg::RST_CONV_SCR;
      m_max_steps = ocm_pkg::RST_MAX_STEPS;
      m_min_steps = ocm_pkg::RST_MIN_STEPS;
      m_init_size = ocm_pkg::RST_STEP_SIZE;
      m_size = ocm_pkg::RST_STEP_SIZE;
      load_bounds(ocm_pkg::RST_STEP_SIZE);
      m_prev_score = 0;
      m_grad_avg = 0;
      m_score_avg = 0;
      m_trend = 0;
      m_stop_step = 0;
      {m_max, m_grad, m_score, m_conv} = 0;
      m_grad_trig = 0;
      m_delta_trig = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: zero previous score, extremes, unused action, clear
      pending_items.push_back(mk(ocm_pkg::ACT_SCORE, 0, 0, 0));
      pending_items.push_back(mk(ocm_pkg::ACT_SCORE, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
      pending_items.push_back(mk(ocm_pkg::ACT_SCORE, 2, 32'hFFFF_FFFF, 32'h8000_0000));
      pending_items.push_back(mk(ocm_pkg::ACT_SCORE, 3, 0, 32'h7FFF_FFFF));
      pending_items.push_back(mk(ocm_pkg::ACT_GRAD, 24'hFF_FFFF, 0, 0));
      pending_items.push_back(mk(ACT_NONE, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_items.push_back(mk(ocm_pkg::ACT_CLEAR, 0, 0, 0));
      pending_items.push_back(mk(ocm_pkg::ACT_SCORE, 5, 100, 32'h0001_0000));
      pending_items.push_back(mk(ocm_pkg::ACT_SCORE, 6, 50, 32'h0001_0000));
      for (int i = 0; i < 6; i++)
         pending_items.push_back(mk(ocm_pkg::ACT_SCORE, 24'(7 + i), 10,
                                    32'(32'h0002_0000 + i * 16)));
      for (int i = 0; i < 6; i++)
         pending_items.push_back(mk(ocm_pkg::ACT_SCORE, 24'(13 + i), 1,
                                    32'(32'h0002_0000 - i * 16)));
      pending_items.push_back(mk(ocm_pkg::ACT_GRAD, 24'hFF_FFFF, 0, 0));
      pending_items.push_back(mk(ocm_pkg::ACT_CLEAR, 24'hFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF));

      for (int p = 0; p < N_PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            set_phase(p);
         end
         for (int n = 0; n < PHASE_LEN; ) begin
            if ($urandom_range(0, 4) == 0) begin
               pending_items.push_back(noise_item());
               n++;
            end else begin
               int len;
               len = $urandom_range(5, 40);
               queue_run(len);
               n += len;
            end
         end
      end
      wait_drained();
      if (expected_status.size() != 0) begin
         $display("%0d results never arrived", expected_status.size());
         errors++;
      end
      $display("covered %0d settings, %0d results checked, %0d with converged set",
               N_PHASES, results_seen, converged_seen);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
